// File: sv/pstc_pkg.sv
// Shared types, register map and reset values for the stick and trigger clamp.
package pstc_pkg;

    localparam int AXIS_W = 16;
    localparam int TRIG_W = 9;
    localparam int REG_W  = 8;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int DEPTH  = 7;

    typedef enum logic [2:0] {
        REG_TRIGGER_DEAD = 3'd0,
        REG_TRIGGER_CAP  = 3'd1,
        REG_LEFT_DEAD    = 3'd2,
        REG_LEFT_LIMIT   = 3'd3,
        REG_LEFT_DIAG    = 3'd4,
        REG_RIGHT_DEAD   = 3'd5,
        REG_RIGHT_LIMIT  = 3'd6,
        REG_RIGHT_DIAG   = 3'd7
    } t_reg_idx;

    localparam logic [REG_W-1:0] RST_TRIGGER_DEAD = 8'd30;
    localparam logic [REG_W-1:0] RST_TRIGGER_CAP  = 8'd180;
    localparam logic [REG_W-1:0] RST_LEFT_DEAD    = 8'd15;
    localparam logic [REG_W-1:0] RST_LEFT_LIMIT   = 8'd72;
    localparam logic [REG_W-1:0] RST_LEFT_DIAG    = 8'd40;
    localparam logic [REG_W-1:0] RST_RIGHT_DEAD   = 8'd15;
    localparam logic [REG_W-1:0] RST_RIGHT_LIMIT  = 8'd59;
    localparam logic [REG_W-1:0] RST_RIGHT_DIAG   = 8'd31;

    typedef struct packed {
        logic [REG_W-1:0] dead;
        logic [REG_W-1:0] limit;
        logic [REG_W-1:0] diag;
    } t_stick_cfg;

endpackage

// File: sv/pstc_in_if.sv
// Input sample channel: two sticks and two triggers.
interface pstc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_x_in;
    logic signed [15:0] left_y_in;
    logic signed [15:0] right_x_in;
    logic signed [15:0] right_y_in;
    logic signed [15:0] left_trig_in;
    logic signed [15:0] right_trig_in;

    modport source (output valid, left_x_in, left_y_in, right_x_in, right_y_in,
                    left_trig_in, right_trig_in, input ready);
    modport sink (input valid, left_x_in, left_y_in, right_x_in, right_y_in,
                  left_trig_in, right_trig_in, output ready);
endinterface

// File: sv/pstc_out_if.sv
// Result channel: clamped sticks and triggers.
interface pstc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_x_out;
    logic signed [15:0] left_y_out;
    logic signed [15:0] right_x_out;
    logic signed [15:0] right_y_out;
    logic signed [8:0]  left_trig_out;
    logic signed [8:0]  right_trig_out;

    modport source (output valid, left_x_out, left_y_out, right_x_out, right_y_out,
                    left_trig_out, right_trig_out, input ready);
    modport sink (input valid, left_x_out, left_y_out, right_x_out, right_y_out,
                  left_trig_out, right_trig_out, output ready);
endinterface

// File: sv/pstc_stick.sv
// Seven-stage dead zone and octagon clamp for one stick.
module pstc_stick (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  pstc_pkg::t_stick_cfg        i_cfg,
    input  logic signed [15:0]          i_x,
    input  logic signed [15:0]          i_y,
    output logic signed [15:0]          o_x,
    output logic signed [15:0]          o_y
);
    import pstc_pkg::*;

    localparam int MAG_W = AXIS_W;
    localparam int D_W   = 25;
    localparam int REM_W = 34;
    localparam int Q_W   = 9;
    localparam int DIV_STAGES = 3;
    localparam int BITS_PER   = Q_W / DIV_STAGES;

    logic [MAG_W-1:0] n1_mx, n1_my;
    logic [MAG_W-1:0] r1_mx, r1_my;
    logic [DEPTH-2:0] r_nx, r_ny;

    logic [23:0]        r2_dx, r2_dy;
    logic signed [26:0] r2_wx, r2_wy;
    logic [15:0]        r2_k;
    logic [MAG_W-1:0]   r2_mx, r2_my;

    logic signed [26:0] n3_d;
    logic               r3_scale;
    logic [D_W-1:0]     r3_d;
    logic [REM_W-1:0]   r3_nx, r3_ny;
    logic [MAG_W-1:0]   r3_mx, r3_my;

    logic [REM_W-1:0]   r_remx [DIV_STAGES+1];
    logic [REM_W-1:0]   r_remy [DIV_STAGES+1];
    logic [Q_W-1:0]     r_qx   [DIV_STAGES+1];
    logic [Q_W-1:0]     r_qy   [DIV_STAGES+1];
    logic [D_W-1:0]     r_dv   [DIV_STAGES+1];
    logic               r_sc   [DIV_STAGES+1];
    logic [MAG_W-1:0]   r_mx   [DIV_STAGES+1];
    logic [MAG_W-1:0]   r_my   [DIV_STAGES+1];

    logic [MAG_W-1:0]   n_fx, n_fy;
    logic [15:0]        r_ox, r_oy;

    function automatic logic [MAG_W-1:0] deadzone(input logic signed [15:0] v,
                                                  input logic [REG_W-1:0] dead);
        logic [MAG_W-1:0] m;
        m = (v > 16'sd0) ? v : 16'(-v);
        return (m <= {8'd0, dead}) ? '0 : m - {8'd0, dead};
    endfunction

    assign n1_mx = deadzone(i_x, i_cfg.dead);
    assign n1_my = deadzone(i_y, i_cfg.dead);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mx <= n1_mx;
            r1_my <= n1_my;
            r_nx  <= {r_nx[DEPTH-3:0], !(i_x > 16'sd0)};
            r_ny  <= {r_ny[DEPTH-3:0], !(i_y > 16'sd0)};
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_dx <= i_cfg.diag * r1_mx;
            r2_dy <= i_cfg.diag * r1_my;
            r2_wx <= ($signed({19'd0, i_cfg.limit}) - $signed({19'd0, i_cfg.diag}))
                     * $signed({11'd0, r1_mx});
            r2_wy <= ($signed({19'd0, i_cfg.limit}) - $signed({19'd0, i_cfg.diag}))
                     * $signed({11'd0, r1_my});
            r2_k  <= i_cfg.diag * i_cfg.limit;
            r2_mx <= r1_mx;
            r2_my <= r1_my;
        end
    end

    always_comb begin
        if (r2_dy <= r2_dx) begin
            n3_d = $signed({3'd0, r2_dx}) + r2_wy;
        end else begin
            n3_d = $signed({3'd0, r2_dy}) + r2_wx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_scale <= n3_d > $signed({11'd0, r2_k});
            r3_d     <= n3_d[D_W-1:0];
            r3_nx    <= {18'd0, r2_k} * {18'd0, r2_mx};
            r3_ny    <= {18'd0, r2_k} * {18'd0, r2_my};
            r3_mx    <= r2_mx;
            r3_my    <= r2_my;
        end
    end

    assign r_remx[0] = r3_nx;
    assign r_remy[0] = r3_ny;
    assign r_qx[0]   = '0;
    assign r_qy[0]   = '0;
    assign r_dv[0]   = r3_d;
    assign r_sc[0]   = r3_scale;
    assign r_mx[0]   = r3_mx;
    assign r_my[0]   = r3_my;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [REM_W-1:0] n_rx, n_ry;
        logic [Q_W-1:0]   n_qx, n_qy;
        always_comb begin
            logic [REM_W-1:0] sh;
            n_rx = r_remx[k];
            n_ry = r_remy[k];
            n_qx = r_qx[k];
            n_qy = r_qy[k];
            for (int j = 0; j < BITS_PER; j++) begin
                sh = {{(REM_W-D_W){1'b0}}, r_dv[k]} << (Q_W - 1 - k * BITS_PER - j);
                if (n_rx >= sh) begin
                    n_rx = n_rx - sh;
                    n_qx[Q_W - 1 - k * BITS_PER - j] = 1'b1;
                end
                if (n_ry >= sh) begin
                    n_ry = n_ry - sh;
                    n_qy[Q_W - 1 - k * BITS_PER - j] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_remx[k+1] <= n_rx;
                r_remy[k+1] <= n_ry;
                r_qx[k+1]   <= n_qx;
                r_qy[k+1]   <= n_qy;
                r_dv[k+1]   <= r_dv[k];
                r_sc[k+1]   <= r_sc[k];
                r_mx[k+1]   <= r_mx[k];
                r_my[k+1]   <= r_my[k];
            end
        end
    end

    assign n_fx = r_sc[DIV_STAGES] ? {{(MAG_W-Q_W){1'b0}}, r_qx[DIV_STAGES]} : r_mx[DIV_STAGES];
    assign n_fy = r_sc[DIV_STAGES] ? {{(MAG_W-Q_W){1'b0}}, r_qy[DIV_STAGES]} : r_my[DIV_STAGES];

    // restore signs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ox <= r_nx[DEPTH-2] ? 16'(-n_fx) : n_fx;
            r_oy <= r_ny[DEPTH-2] ? 16'(-n_fy) : n_fy;
        end
    end

    assign o_x = $signed(r_ox);
    assign o_y = $signed(r_oy);
endmodule

// File: sv/pad_stick_trigger_clamp.sv
// Top level of the gamepad stick and trigger clamp.
// Usage:
//   i_in carries one controller sample per beat (two sticks, two triggers);
//   o_out carries the conditioned sample. Each accepted beat gives exactly one
//   result beat, in order.
//   Throughput is one sample per cycle while the output is not stalled. The
//   path is set by the stick stages: magnitude and dead zone, products,
//   octagon sum and numerators, three 3-bit divider stages, and the sign
//   restore in the output register.
//   The whole pipeline advances together; when o_out.ready is low while a
//   result is shown, every stage holds and i_in.ready drops, so nothing is
//   lost or repeated.
//   The APB port holds eight 8-bit registers at byte addresses 4*i; write
//   them only while the pipeline is empty. pready is always high.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   register defaults.
module pad_stick_trigger_clamp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pstc_in_if.sink                      i_in,
    pstc_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pstc_pkg::ADDR_W-1:0]  paddr,
    input  logic [pstc_pkg::DATA_W-1:0]  pwdata,
    output logic [pstc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import pstc_pkg::*;

    logic [REG_W-1:0] r_trig_dead, r_trig_cap;
    logic [REG_W-1:0] r_l_dead, r_l_lim, r_l_diag;
    logic [REG_W-1:0] r_r_dead, r_r_lim, r_r_diag;
    logic [DEPTH-1:0] r_vld;
    logic             w_en;
    t_reg_idx         w_idx;
    t_stick_cfg       w_lcfg, w_rcfg;
    logic [TRIG_W-1:0] r_lt [DEPTH];
    logic [TRIG_W-1:0] r_rt [DEPTH];

    function automatic logic [TRIG_W-1:0] trig(input logic signed [15:0] t,
                                               input logic [REG_W-1:0] lo,
                                               input logic [REG_W-1:0] hi);
        logic signed [9:0] c;
        if (t <= $signed({8'd0, lo})) begin
            return '0;
        end
        c = (t > $signed({8'd0, hi})) ? $signed({2'd0, hi}) : 10'(t);
        return TRIG_W'(c - $signed({2'd0, lo}));
    endfunction

    assign w_en    = !r_vld[DEPTH-1] || o_out.ready;
    assign i_in.ready = w_en;
    assign w_idx   = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_dead <= RST_TRIGGER_DEAD;
            r_trig_cap  <= RST_TRIGGER_CAP;
            r_l_dead    <= RST_LEFT_DEAD;
            r_l_lim     <= RST_LEFT_LIMIT;
            r_l_diag    <= RST_LEFT_DIAG;
            r_r_dead    <= RST_RIGHT_DEAD;
            r_r_lim     <= RST_RIGHT_LIMIT;
            r_r_diag    <= RST_RIGHT_DIAG;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_TRIGGER_DEAD: r_trig_dead <= pwdata[REG_W-1:0];
                REG_TRIGGER_CAP:  r_trig_cap  <= pwdata[REG_W-1:0];
                REG_LEFT_DEAD:    r_l_dead    <= pwdata[REG_W-1:0];
                REG_LEFT_LIMIT:   r_l_lim     <= pwdata[REG_W-1:0];
                REG_LEFT_DIAG:    r_l_diag    <= pwdata[REG_W-1:0];
                REG_RIGHT_DEAD:   r_r_dead    <= pwdata[REG_W-1:0];
                REG_RIGHT_LIMIT:  r_r_lim     <= pwdata[REG_W-1:0];
                REG_RIGHT_DIAG:   r_r_diag    <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_TRIGGER_DEAD: prdata[REG_W-1:0] = r_trig_dead;
            REG_TRIGGER_CAP:  prdata[REG_W-1:0] = r_trig_cap;
            REG_LEFT_DEAD:    prdata[REG_W-1:0] = r_l_dead;
            REG_LEFT_LIMIT:   prdata[REG_W-1:0] = r_l_lim;
            REG_LEFT_DIAG:    prdata[REG_W-1:0] = r_l_diag;
            REG_RIGHT_DEAD:   prdata[REG_W-1:0] = r_r_dead;
            REG_RIGHT_LIMIT:  prdata[REG_W-1:0] = r_r_lim;
            REG_RIGHT_DIAG:   prdata[REG_W-1:0] = r_r_diag;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lt[0] <= trig(i_in.left_trig_in, r_trig_dead, r_trig_cap);
            r_rt[0] <= trig(i_in.right_trig_in, r_trig_dead, r_trig_cap);
            for (int i = 1; i < DEPTH; i++) begin
                r_lt[i] <= r_lt[i-1];
                r_rt[i] <= r_rt[i-1];
            end
        end
    end

    assign w_lcfg = '{dead: r_l_dead, limit: r_l_lim, diag: r_l_diag};
    assign w_rcfg = '{dead: r_r_dead, limit: r_r_lim, diag: r_r_diag};

    pstc_stick u_left (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cfg (w_lcfg),
        .i_x   (i_in.left_x_in),
        .i_y   (i_in.left_y_in),
        .o_x   (o_out.left_x_out),
        .o_y   (o_out.left_y_out)
    );

    pstc_stick u_right (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cfg (w_rcfg),
        .i_x   (i_in.right_x_in),
        .i_y   (i_in.right_y_in),
        .o_x   (o_out.right_x_out),
        .o_y   (o_out.right_y_out)
    );

    assign o_out.valid          = r_vld[DEPTH-1];
    assign o_out.left_trig_out  = $signed(r_lt[DEPTH-1]);
    assign o_out.right_trig_out = $signed(r_rt[DEPTH-1]);
endmodule

// File: sv/pstc_check.sv
// Port-level checks for the stick and trigger clamp, bound to the top level.
module pstc_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic pready
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("result valid right after reset");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped under stall");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not track output stall");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind pad_stick_trigger_clamp pstc_check u_pstc_check (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .pready    (pready)
);

// File: tb/sv/pstc_clamp_checker.sv
// Checker: watches both channels, predicts each conditioned sample and compares it.
module pstc_clamp_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pstc_in_if.sink                     i_mon_in,
    pstc_out_if.sink                    i_mon_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [pstc_pkg::ADDR_W-1:0] paddr,
    input  logic [pstc_pkg::DATA_W-1:0] pwdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pstc_pkg::*;

    typedef struct packed {
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [8:0]  lt;
        logic signed [8:0]  rt;
    } t_sample_out;

    logic [REG_W-1:0] cfg [8];
    t_sample_out      expected_q [$];

    function automatic void clamp_axis_pair(input logic signed [15:0] ax, ay,
                                            input logic [REG_W-1:0] dz, lim, dg,
                                            output logic signed [15:0] ox, oy);
        longint x, y, d, l, g, z;
        bit     nx, ny;
        x = ax;
        y = ay;
        l = lim;
        g = dg;
        z = dz;
        nx = !(x > 0);
        ny = !(y > 0);
        if (nx) x = -x;
        if (ny) y = -y;
        x = (x <= z) ? 0 : x - z;
        y = (y <= z) ? 0 : y - z;
        if (g * y <= g * x) d = g * x + (l - g) * y;
        else d = g * y + (l - g) * x;
        if (g * l < d) begin
            x = g * l * x / d;
            y = g * l * y / d;
        end
        if (nx) x = -x;
        if (ny) y = -y;
        ox = x[15:0];
        oy = y[15:0];
    endfunction

    function automatic logic signed [8:0] clamp_trigger(input logic signed [15:0] raw);
        longint t;
        t = raw;
        if (t <= longint'(cfg[REG_TRIGGER_DEAD])) t = 0;
        else begin
            if (longint'(cfg[REG_TRIGGER_CAP]) < t) t = cfg[REG_TRIGGER_CAP];
            t = t - cfg[REG_TRIGGER_DEAD];
        end
        return t[8:0];
    endfunction

    function automatic t_sample_out predict_sample();
        t_sample_out r;
        clamp_axis_pair(i_mon_in.left_x_in, i_mon_in.left_y_in, cfg[REG_LEFT_DEAD],
                        cfg[REG_LEFT_LIMIT], cfg[REG_LEFT_DIAG], r.lx, r.ly);
        clamp_axis_pair(i_mon_in.right_x_in, i_mon_in.right_y_in, cfg[REG_RIGHT_DEAD],
                        cfg[REG_RIGHT_LIMIT], cfg[REG_RIGHT_DIAG], r.rx, r.ry);
        r.lt = clamp_trigger(i_mon_in.left_trig_in);
        r.rt = clamp_trigger(i_mon_in.right_trig_in);
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_sample_out got, want;
        if (!i_rst_n) begin
            cfg[REG_TRIGGER_DEAD] <= RST_TRIGGER_DEAD;
            cfg[REG_TRIGGER_CAP]  <= RST_TRIGGER_CAP;
            cfg[REG_LEFT_DEAD]    <= RST_LEFT_DEAD;
            cfg[REG_LEFT_LIMIT]   <= RST_LEFT_LIMIT;
            cfg[REG_LEFT_DIAG]    <= RST_LEFT_DIAG;
            cfg[REG_RIGHT_DEAD]   <= RST_RIGHT_DEAD;
            cfg[REG_RIGHT_LIMIT]  <= RST_RIGHT_LIMIT;
            cfg[REG_RIGHT_DIAG]   <= RST_RIGHT_DIAG;
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
                cfg[paddr[ADDR_W-1:2]] <= pwdata[REG_W-1:0];
            if (i_mon_in.valid && i_mon_in.ready)
                expected_q.push_back(predict_sample());
            if (i_mon_out.valid && i_mon_out.ready) begin
                got = '{i_mon_out.left_x_out, i_mon_out.left_y_out, i_mon_out.right_x_out,
                        i_mon_out.right_y_out, i_mon_out.left_trig_out,
                        i_mon_out.right_trig_out};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected beat, actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected lx %0d ly %0d rx %0d ry %0d lt %0d rt %0d",
                                 $time, want.lx, want.ly, want.rx, want.ry, want.lt, want.rt);
                        $display("%0t: actual   lx %0d ly %0d rx %0d ry %0d lt %0d rt %0d",
                                 $time, got.lx, got.ly, got.rx, got.ry, got.lt, got.rt);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: tb/sv/tb.sv
// Top of the clamp testbench: clock, reset, stimulus, register writes and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pstc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                cycle_count = 0;
    int                hold_off = 0;
    bit                long_hold_req = 0;

    pstc_in_if  in_ch ();
    pstc_out_if out_ch ();

    pad_stick_trigger_clamp dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pstc_clamp_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mon_in     (in_ch.sink),
        .i_mon_out    (out_ch.sink),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.left_x_in = '0;
        in_ch.left_y_in = '0;
        in_ch.right_x_in = '0;
        in_ch.right_y_in = '0;
        in_ch.left_trig_in = '0;
        in_ch.right_trig_in = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: own stall pattern plus repeated long hold-offs while requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (long_hold_req && hold_off == 0) begin
            hold_off <= 60;
            out_ch.ready <= 1'b0;
        end else if (hold_off > 1) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end else begin
            hold_off <= 0;
            case (cycle_count[11:10])
                2'd0:    out_ch.ready <= 1'b1;
                2'd1:    out_ch.ready <= ($urandom_range(3) != 0);
                default: out_ch.ready <= ($urandom_range(1) == 0);
            endcase
        end
    end

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sd0;
            3:       return 16'($urandom_range(300) - 150);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic signed [15:0] pick_trigger();
        case ($urandom_range(5))
            0:       return 16'($urandom());
            1:       return 16'(-($urandom_range(300)));
            default: return 16'($urandom_range(280));
        endcase
    endfunction

    task automatic send_sample(input logic signed [15:0] lx, ly, rx, ry, lt, rt);
        in_ch.valid <= 1'b1;
        in_ch.left_x_in <= lx;
        in_ch.left_y_in <= ly;
        in_ch.right_x_in <= rx;
        in_ch.right_y_in <= ry;
        in_ch.left_trig_in <= lt;
        in_ch.right_trig_in <= rt;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_random(input int count);
        int burst;
        burst = 0;
        repeat (count) begin
            if (burst == 0) begin
                burst = $urandom_range(20, 1);
                if ($urandom_range(2) == 0) begin
                    in_ch.valid <= 1'b0;
                    repeat ($urandom_range(6, 1)) @(posedge i_clk);
                end
            end
            burst--;
            send_sample(pick_axis(), pick_axis(), pick_axis(), pick_axis(),
                        pick_trigger(), pick_trigger());
        end
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [REG_W-1:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= {24'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_all(input logic [REG_W-1:0] td, tc, ld, ll, lg, rd, rl, rg);
        write_reg(REG_TRIGGER_DEAD, td);
        write_reg(REG_TRIGGER_CAP, tc);
        write_reg(REG_LEFT_DEAD, ld);
        write_reg(REG_LEFT_LIMIT, ll);
        write_reg(REG_LEFT_DIAG, lg);
        write_reg(REG_RIGHT_DEAD, rd);
        write_reg(REG_RIGHT_LIMIT, rl);
        write_reg(REG_RIGHT_DIAG, rg);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_sample(0, 0, 0, 0, 0, 0);
        send_sample(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 30, 31);
        send_sample(15, -15, 16, -16, 180, 181);
        send_sample(80, 20, -20, 80, 200, -1);
        send_sample(50, 50, -60, -60, 29, 255);
        send_sample(16'shffff, 1, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
        in_ch.valid <= 1'b0;
        drain();

        write_all(0, 0, 0, 0, 0, 0, 0, 0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 1);
        send_sample(100, 3, 5, 100, 16'sh8000, 16'sh7fff);
        in_ch.valid <= 1'b0;
        drain();

        write_all(255, 0, 0, 255, 0, 0, 255, 255);
        send_sample(16'sh8000, 0, 16'sh8000, 16'sh8000, 256, 16'sh7fff);
        send_sample(300, 300, 7, 300, 255, 1000);
        in_ch.valid <= 1'b0;
        drain();

        write_all(255, 255, 255, 255, 255, 255, 255, 255);
        send_sample(255, 256, -256, -255, 255, 256);
        send_sample(16'sh7fff, 16'sh8000, 1000, 2000, 16'sh7fff, 0);
        in_ch.valid <= 1'b0;
        drain();

        long_hold_req = 1;
        write_all(RST_TRIGGER_DEAD, RST_TRIGGER_CAP, RST_LEFT_DEAD, RST_LEFT_LIMIT,
                  RST_LEFT_DIAG, RST_RIGHT_DEAD, RST_RIGHT_LIMIT, RST_RIGHT_DIAG);
        send_random(300);
        long_hold_req = 0;
        drain();

        repeat (4) begin
            write_all(REG_W'($urandom()), REG_W'($urandom()), REG_W'($urandom_range(40)),
                      REG_W'($urandom()), REG_W'($urandom()), REG_W'($urandom_range(40)),
                      REG_W'($urandom()), REG_W'($urandom()));
            send_random(235);
            drain();
        end

        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
